// File: design/tfn_pkg.sv
// Shared widths and pipeline word types for the triangle face normal core.
// No dependencies; every other design file refers to it by scoped names.
package tfn_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int EDGE_W     = COORD_BITS + 1;              // B-A, C-A
    localparam int PROD_W     = 2 * EDGE_W;                  // edge products
    localparam int CROSS_W    = PROD_W + 1;                  // signed cross term
    localparam int MAG_W      = PROD_W;                      // |cross term|
    localparam int SQ_W       = 2 * MAG_W;                   // squared term
    localparam int SUM_W      = SQ_W + 2;                    // squared length
    localparam int ROOT_STEPS = NORMAL_FRAC_BITS + 2;        // bits of the root
    localparam int WORK_W     = SQ_W + 2 * NORMAL_FRAC_BITS + 8;
    localparam int OUT_W      = NORMAL_FRAC_BITS + 2;
    localparam int LANES      = 3;

    // one component lane of the root recurrence
    typedef struct packed {
        logic [WORK_W-1:0]     resid;   // c^2 * 2^(2F+2) - T^2 * S
        logic [WORK_W-1:0]     acc;     // T * S
        logic [ROOT_STEPS-1:0] root;    // T, settled from the top bit down
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0]  lane;
        logic [SUM_W-1:0]   sum;
        logic [LANES-1:0]   neg;
        logic               degen;
    } t_root_word;

endpackage

// File: design/tfn_in_if.sv
// Channel interfaces of the face normal core: triangle in, normal out.
// Depends on tfn_pkg for field widths.
interface tfn_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tfn_pkg::COORD_BITS-1:0] first_x;
    logic signed [tfn_pkg::COORD_BITS-1:0] first_y;
    logic signed [tfn_pkg::COORD_BITS-1:0] first_z;
    logic signed [tfn_pkg::COORD_BITS-1:0] second_x;
    logic signed [tfn_pkg::COORD_BITS-1:0] second_y;
    logic signed [tfn_pkg::COORD_BITS-1:0] second_z;
    logic signed [tfn_pkg::COORD_BITS-1:0] third_x;
    logic signed [tfn_pkg::COORD_BITS-1:0] third_y;
    logic signed [tfn_pkg::COORD_BITS-1:0] third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, output ready);
endinterface

interface tfn_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tfn_pkg::OUT_W-1:0]    normal_x;
    logic signed [tfn_pkg::OUT_W-1:0]    normal_y;
    logic signed [tfn_pkg::OUT_W-1:0]    normal_z;
    logic                                degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: design/triangle_face_normal_core.sv
// Unit face normal of a triangle: edges B-A and C-A, exact cross product,
// then each component rounded to nearest Q1.14 against the exact length.
// Takes one triangle per clock while o_out is not stalled; the pipeline has
// six front stages, one stage per root bit (16) and the output register.
// Stalls ripple back stage by stage, so empty stages fill while the output
// waits. A zero cross product gives a zero normal with degenerate set.
// Depends on tfn_pkg, tfn_in_if/tfn_out_if, tfn_front, tfn_root and tfn_out.
module triangle_face_normal_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfn_in_if.sink     i_in,
    tfn_out_if.source  o_out
);
    logic                front_valid, front_ready;
    logic                root_valid, root_ready;
    tfn_pkg::t_root_word front_word, root_word;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_word  (front_word)
    );

    tfn_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_word  (front_word),
        .o_valid (root_valid),
        .i_ready (root_ready),
        .o_word  (root_word)
    );

    tfn_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (root_valid),
        .o_ready (root_ready),
        .i_word  (root_word),
        .o_out   (o_out)
    );

endmodule

// File: design/tfn_front.sv
// Front end: edges, cross product, squared terms and squared length, six stages.
// Depends on tfn_pkg and tfn_in_if.
module tfn_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tfn_in_if.sink              i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output tfn_pkg::t_root_word o_word
);
    localparam int NST = 6;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign i_in.ready = en[0];
    assign o_valid    = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 0: edges u = B-A, v = C-A
    localparam int CM = tfn_pkg::COORD_BITS - 1;
    logic signed [tfn_pkg::EDGE_W-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ux <= $signed({i_in.second_x[CM], i_in.second_x})
                  - $signed({i_in.first_x[CM], i_in.first_x});
            r_uy <= $signed({i_in.second_y[CM], i_in.second_y})
                  - $signed({i_in.first_y[CM], i_in.first_y});
            r_uz <= $signed({i_in.second_z[CM], i_in.second_z})
                  - $signed({i_in.first_z[CM], i_in.first_z});
            r_vx <= $signed({i_in.third_x[CM], i_in.third_x})
                  - $signed({i_in.first_x[CM], i_in.first_x});
            r_vy <= $signed({i_in.third_y[CM], i_in.third_y})
                  - $signed({i_in.first_y[CM], i_in.first_y});
            r_vz <= $signed({i_in.third_z[CM], i_in.third_z})
                  - $signed({i_in.first_z[CM], i_in.first_z});
        end
    end

    // stage 1: the six products
    logic signed [tfn_pkg::PROD_W-1:0] r_p [tfn_pkg::LANES];
    logic signed [tfn_pkg::PROD_W-1:0] r_q [tfn_pkg::LANES];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p[0] <= r_uy * r_vz;
            r_q[0] <= r_uz * r_vy;
            r_p[1] <= r_uz * r_vx;
            r_q[1] <= r_ux * r_vz;
            r_p[2] <= r_ux * r_vy;
            r_q[2] <= r_uy * r_vx;
        end
    end

    // stage 2: cross terms
    logic signed [tfn_pkg::CROSS_W-1:0] r_c [tfn_pkg::LANES];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int j = 0; j < tfn_pkg::LANES; j++) begin
                r_c[j] <= $signed({r_p[j][tfn_pkg::PROD_W-1], r_p[j]})
                        - $signed({r_q[j][tfn_pkg::PROD_W-1], r_q[j]});
            end
        end
    end

    // stage 3: magnitude and sign
    logic [tfn_pkg::MAG_W-1:0]   r_mag [tfn_pkg::LANES];
    logic [tfn_pkg::LANES-1:0]   r_neg3;
    logic [tfn_pkg::CROSS_W-1:0] n_absv [tfn_pkg::LANES];

    always_comb begin
        for (int j = 0; j < tfn_pkg::LANES; j++) begin
            n_absv[j] = r_c[j][tfn_pkg::CROSS_W-1] ? -r_c[j] : r_c[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int j = 0; j < tfn_pkg::LANES; j++) begin
                r_mag[j]  <= n_absv[j][tfn_pkg::MAG_W-1:0];
                r_neg3[j] <= r_c[j][tfn_pkg::CROSS_W-1];
            end
        end
    end

    // stage 4: squares
    logic [tfn_pkg::SQ_W-1:0]  r_sq [tfn_pkg::LANES];
    logic [tfn_pkg::LANES-1:0] r_neg4;
    logic                      r_degen4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int j = 0; j < tfn_pkg::LANES; j++) begin
                r_sq[j] <= r_mag[j] * r_mag[j];
            end
            r_neg4   <= r_neg3;
            r_degen4 <= (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
        end
    end

    // stage 5: squared length, seed the root recurrence
    tfn_pkg::t_root_word n_word;

    always_comb begin
        n_word       = '0;
        n_word.sum   = tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
                     + tfn_pkg::SUM_W'(r_sq[2]);
        n_word.neg   = r_neg4;
        n_word.degen = r_degen4;
        for (int j = 0; j < tfn_pkg::LANES; j++) begin
            n_word.lane[j].resid = tfn_pkg::WORK_W'(r_sq[j])
                                 << (2 * tfn_pkg::NORMAL_FRAC_BITS + 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            o_word <= n_word;
        end
    end

endmodule

// File: design/tfn_root.sv
// Root pipeline: one stage per bit of T = floor(sqrt(c^2 * 2^(2F+2) / S)),
// restoring recurrence on all three lanes. Depends on tfn_pkg.
module tfn_root (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfn_pkg::t_root_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output tfn_pkg::t_root_word o_word
);
    localparam int NST = tfn_pkg::ROOT_STEPS;

    logic [NST-1:0]      r_v;
    logic [NST-1:0]      en;
    tfn_pkg::t_root_word r_w [NST];
    tfn_pkg::t_root_word n_w [NST];

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_word  = r_w[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_step
        localparam int K = NST - 1 - g;   // root bit settled here

        tfn_pkg::t_root_word w_in;
        logic [tfn_pkg::WORK_W-1:0] trial [tfn_pkg::LANES];

        if (g == 0) begin : g_first
            assign w_in = i_word;
        end else begin : g_next
            assign w_in = r_w[g-1];
        end

        // T+2^K: T^2 S grows by (T S) 2^(K+1) + S 2^(2K)
        always_comb begin
            n_w[g] = w_in;
            for (int j = 0; j < tfn_pkg::LANES; j++) begin
                trial[j] = (w_in.lane[j].acc << (K + 1))
                         + (tfn_pkg::WORK_W'(w_in.sum) << (2 * K));
                if (trial[j] <= w_in.lane[j].resid) begin
                    n_w[g].lane[j].resid   = w_in.lane[j].resid - trial[j];
                    n_w[g].lane[j].acc     = w_in.lane[j].acc
                                           + (tfn_pkg::WORK_W'(w_in.sum) << K);
                    n_w[g].lane[j].root[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_w[g] <= n_w[g];
            end
        end
    end

endmodule

// File: design/tfn_out.sv
// Output stage: rounds T to the Q1.F code, applies sign, degenerate case.
// Depends on tfn_pkg and tfn_out_if.
module tfn_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfn_pkg::t_root_word i_word,
    tfn_out_if.source           o_out
);
    logic                      r_v;
    logic [tfn_pkg::OUT_W-1:0] r_n [tfn_pkg::LANES];
    logic                      r_degen;
    logic [tfn_pkg::OUT_W-1:0] n_n [tfn_pkg::LANES];
    logic [tfn_pkg::OUT_W:0]   n_inc [tfn_pkg::LANES];

    assign o_ready = !r_v || o_out.ready;

    // q = (T+1)/2 is the largest q with (2q-1)^2 S <= c^2 2^(2F+2)
    always_comb begin
        for (int j = 0; j < tfn_pkg::LANES; j++) begin
            n_inc[j] = {1'b0, i_word.lane[j].root} + 1'b1;
            n_n[j]   = i_word.neg[j] ? -n_inc[j][tfn_pkg::OUT_W:1]
                                     : n_inc[j][tfn_pkg::OUT_W:1];
            if (i_word.degen) begin
                n_n[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_n     <= n_n;
            r_degen <= i_word.degen;
        end
    end

    assign o_out.valid      = r_v;
    assign o_out.normal_x   = r_n[0];
    assign o_out.normal_y   = r_n[1];
    assign o_out.normal_z   = r_n[2];
    assign o_out.degenerate = r_degen;

endmodule

// File: design/tfn_checker.sv
// Port-level checks of the face normal core, bound to the top level.
// Depends on tfn_pkg and triangle_face_normal_core.
module tfn_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [tfn_pkg::OUT_W-1:0] i_nx,
    input logic signed [tfn_pkg::OUT_W-1:0] i_ny,
    input logic signed [tfn_pkg::OUT_W-1:0] i_nz,
    input logic                             i_degen
);
    localparam int ONE = 1 << tfn_pkg::NORMAL_FRAC_BITS;

    logic [5:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 6'(i_in_valid && i_in_ready)
                        - 6'(i_out_valid && i_out_ready);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degen |-> i_nx == '0 && i_ny == '0 && i_nz == '0)
        else $error("degenerate word with non-zero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_nx >= -ONE && i_nx <= ONE && i_ny >= -ONE
                        && i_ny <= ONE && i_nz >= -ONE && i_nz <= ONE)
        else $error("normal component out of range");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != '0)
        else $error("result word with no triangle in flight");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while output side free");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_nx        (o_out.normal_x),
    .i_ny        (o_out.normal_y),
    .i_nz        (o_out.normal_z),
    .i_degen     (o_out.degenerate)
);
